[hw/rtl/sphq_pkg.sv]
// Shared types, constants and fixed-point helpers for the sphere drag block.
// No dependencies; imported by every module of the block.
`default_nettype none
package sphq_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int SQ_STAGES   = 32;   // one root bit per stage
    localparam int DIV_STAGES  = 34;   // one quotient bit per stage
    localparam logic [31:0] PI_Q = 32'd205887;

    // Jacobian entry order: xx, xy, xz, yy, yz, zz
    localparam int PAIR_I [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_J [6] = '{0, 1, 2, 1, 2, 2};

    typedef enum logic [1:0] {
        CFG_DRAG_COEF = 2'd0,
        CFG_DENSITY   = 2'd1,
        CFG_JAC_SCALE = 2'd2,
        CFG_JAC_EN    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] drag_coef;
        logic [31:0] density;
        logic [31:0] jac_scale;
        logic        jac_en;
    } t_cfg;

    // classified ball, front to back
    typedef struct packed {
        logic [15:0]      idx;
        logic             last;
        logic             active;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [31:0]      radius;
    } t_item;

    // per-ball data carried down the back pipeline
    typedef struct packed {
        logic [15:0]      idx;
        logic             last;
        logic             active;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [31:0]      k;
    } t_meta;

    typedef struct packed {
        logic [15:0]      idx;
        logic             active;
        logic [2:0][31:0] frc;
        logic [5:0][31:0] jac;
        logic             last;
    } t_res;

    // unsigned Q16.16 multiply, truncated, saturated
    function automatic logic [31:0] umulq(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        if (|p[63:48]) return 32'hFFFF_FFFF;
        return p[47:16];
    endfunction

    // sign-magnitude to saturated two's complement
    function automatic logic [31:0] pack(input logic neg, input logic [47:0] mag);
        if (neg) begin
            if (mag >= 48'h8000_0000) return 32'h8000_0000;
            return 32'(~mag[31:0] + 32'd1);
        end
        if (mag > 48'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return mag[31:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/sphq_front.sv]
// Front end: takes a ball, decides activity, forms saturated relative velocity.
// Depends on sphq_pkg.
`default_nettype none
module sphq_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    output logic                 o_full,
    input  wire  [15:0]          i_node_index,
    input  wire  [2:0][31:0]     i_vel,
    input  wire  [2:0][31:0]     i_wvel,
    input  wire  [31:0]          i_node_height,
    input  wire  [31:0]          i_ball_radius,
    input  wire  [31:0]          i_birth_time,
    input  wire  [31:0]          i_sim_time,
    input  wire                  i_last_ball,
    output logic                 o_valid,
    output sphq_pkg::t_item      o_item,
    input  wire                  i_ready
);
    import sphq_pkg::*;

    logic  r_v;
    t_item r_item;
    t_item n_item;
    logic  take;

    assign take    = !r_v || i_ready;
    assign o_full  = !take;
    assign o_valid = r_v;
    assign o_item  = r_item;

    always_comb begin
        logic [32:0] diff;
        logic [31:0] d;
        n_item        = '0;
        n_item.idx    = i_node_index;
        n_item.last   = i_last_ball;
        n_item.radius = i_ball_radius;
        n_item.active = ($signed(i_node_height) <= 0) && (i_sim_time >= i_birth_time);
        for (int i = 0; i < 3; i++) begin
            diff = {i_vel[i][31], i_vel[i]} - {i_wvel[i][31], i_wvel[i]};
            if (diff[32] != diff[31]) d = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else d = diff[31:0];
            n_item.neg[i] = d[31];
            n_item.mag[i] = d[31] ? 32'(~d + 32'd1) : d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (take) begin
            r_v <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_push) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/sphq_fifo.sv]
// Short queue between the front and back halves.
// Depends on sphq_pkg for the item type.
`default_nettype none
module sphq_fifo #(
    parameter int DEPTH = sphq_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_wr,
    input  sphq_pkg::t_item  i_wdata,
    output logic             o_full,
    output logic             o_valid,
    output sphq_pkg::t_item  o_rdata,
    input  wire              i_rd
);
    import sphq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           wr_ok, rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && o_valid;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) return '0;
        return AW'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) r_wp <= bump(r_wp);
            if (rd_ok) r_rp <= bump(r_rp);
            if (wr_ok && !rd_ok) r_cnt <= CW'(r_cnt + 1'b1);
            else if (rd_ok && !wr_ok) r_cnt <= CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) mem[r_wp] <= i_wdata;
    end

endmodule
`default_nettype wire

[hw/rtl/sphq_back.sv]
// Back end: coefficient, pipelined square root, force, pipelined dividers, Jacobian.
// Depends on sphq_pkg. All stages advance together when the output register frees.
`default_nettype none
module sphq_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  sphq_pkg::t_cfg   i_cfg,
    input  wire              i_valid,
    input  sphq_pkg::t_item  i_item,
    output logic             o_rd,
    output logic             o_valid,
    output sphq_pkg::t_res   o_res,
    input  wire              i_pop
);
    import sphq_pkg::*;

    logic en;
    assign en   = !o_valid || i_pop;
    assign o_rd = en && i_valid;

    // config-only part of k: cd*rho*pi/2
    logic [31:0] r_t1, r_t2;
    always_ff @(posedge i_clk) begin
        r_t1 <= umulq(i_cfg.drag_coef, i_cfg.density);
        r_t2 <= umulq(r_t1, PI_Q) >> 1;
    end

    // S1: squares, r^2
    logic             r_s1_v;
    t_item            r_s1_item;
    logic [2:0][63:0] r_s1_sq;
    logic [31:0]      r_s1_r2;
    // S2: sum, k
    logic             r_s2_v;
    t_meta            r_s2_meta;
    logic [63:0]      r_s2_v2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_item <= i_item;
            r_s1_r2   <= umulq(i_item.radius, i_item.radius);
            for (int i = 0; i < 3; i++)
                r_s1_sq[i] <= {32'd0, i_item.mag[i]} * {32'd0, i_item.mag[i]};
            r_s2_meta.idx    <= r_s1_item.idx;
            r_s2_meta.last   <= r_s1_item.last;
            r_s2_meta.active <= r_s1_item.active;
            r_s2_meta.neg    <= r_s1_item.neg;
            r_s2_meta.mag    <= r_s1_item.mag;
            r_s2_meta.k      <= umulq(r_t2, r_s1_r2);
            r_s2_v2          <= r_s1_sq[0] + r_s1_sq[1] + r_s1_sq[2];
        end
    end

    // square root: one root bit per stage
    logic        r_qv [SQ_STAGES];
    t_meta       r_qm [SQ_STAGES];
    logic [63:0] r_qn [SQ_STAGES];
    logic [33:0] r_qr [SQ_STAGES];
    logic [31:0] r_qq [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sqrt
        localparam int B = 2 * (SQ_STAGES - 1 - s);
        t_meta       m_in;
        logic [63:0] n_in;
        logic [33:0] rem_in;
        logic [31:0] q_in;
        logic [35:0] sh, trial;
        if (s == 0) begin : g_first
            assign m_in   = r_s2_meta;
            assign n_in   = r_s2_v2;
            assign rem_in = '0;
            assign q_in   = '0;
        end else begin : g_next
            assign m_in   = r_qm[s-1];
            assign n_in   = r_qn[s-1];
            assign rem_in = r_qr[s-1];
            assign q_in   = r_qq[s-1];
        end
        assign sh    = {rem_in, n_in[B+1:B]};
        assign trial = {2'b00, q_in, 2'b01};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_qm[s] <= m_in;
                r_qn[s] <= n_in;
                if (sh >= trial) begin
                    r_qr[s] <= 34'(sh - trial);
                    r_qq[s] <= {q_in[30:0], 1'b1};
                end else begin
                    r_qr[s] <= sh[33:0];
                    r_qq[s] <= {q_in[30:0], 1'b0};
                end
            end
        end
    end

    // S3: saturated |d|, ks
    logic        r_s3_v;
    t_meta       r_s3_meta;
    logic [31:0] r_s3_dmag, r_s3_ks;
    // S4: kd, cross products
    logic             r_s4_v;
    t_meta            r_s4_meta;
    logic [31:0]      r_s4_dmag, r_s4_ks, r_s4_kd;
    logic [5:0][63:0] r_s4_prod;

    logic [63:0] kd_p;
    assign kd_p = {32'd0, r_s3_meta.k} * {32'd0, r_s3_dmag};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_meta <= r_qm[SQ_STAGES-1];
            r_s3_dmag <= r_qq[SQ_STAGES-1][31] ? 32'h7FFF_FFFF : r_qq[SQ_STAGES-1];
            r_s3_ks   <= umulq(r_qm[SQ_STAGES-1].k, i_cfg.jac_scale);
            r_s4_meta <= r_s3_meta;
            r_s4_dmag <= r_s3_dmag;
            r_s4_ks   <= r_s3_ks;
            r_s4_kd   <= (|kd_p[63:47]) ? 32'h7FFF_FFFF : {1'b0, kd_p[46:16]};
            for (int p = 0; p < 6; p++)
                r_s4_prod[p] <= {32'd0, r_s3_meta.mag[PAIR_I[p]]}
                              * {32'd0, r_s3_meta.mag[PAIR_J[p]]};
        end
    end

    // dividers: six restoring dividers, one quotient bit per stage
    logic                         r_dv   [DIV_STAGES];
    t_meta                        r_dm   [DIV_STAGES];
    logic [31:0]                  r_dd   [DIV_STAGES];
    logic [31:0]                  r_dks  [DIV_STAGES];
    logic [31:0]                  r_dkd  [DIV_STAGES];
    logic [5:0][63:0]             r_dn   [DIV_STAGES];
    logic [5:0][30:0]             r_drem [DIV_STAGES];
    logic [5:0][DIV_STAGES-1:0]   r_dq   [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        localparam int BIT = DIV_STAGES - 1 - s;
        t_meta                      m_in;
        logic [31:0]                d_in, ks_in, kd_in;
        logic [5:0][63:0]           n_in;
        logic [5:0][30:0]           rem_in;
        logic [5:0][DIV_STAGES-1:0] q_in;
        if (s == 0) begin : g_first
            assign m_in  = r_s4_meta;
            assign d_in  = r_s4_dmag;
            assign ks_in = r_s4_ks;
            assign kd_in = r_s4_kd;
            assign n_in  = r_s4_prod;
            assign q_in  = '0;
            for (genvar p = 0; p < 6; p++) begin : g_init
                assign rem_in[p] = 31'(r_s4_prod[p] >> DIV_STAGES);
            end
        end else begin : g_next
            assign m_in   = r_dm[s-1];
            assign d_in   = r_dd[s-1];
            assign ks_in  = r_dks[s-1];
            assign kd_in  = r_dkd[s-1];
            assign n_in   = r_dn[s-1];
            assign rem_in = r_drem[s-1];
            assign q_in   = r_dq[s-1];
        end
        always_ff @(posedge i_clk) begin
            logic [31:0] sh;
            if (en) begin
                r_dm[s]  <= m_in;
                r_dd[s]  <= d_in;
                r_dks[s] <= ks_in;
                r_dkd[s] <= kd_in;
                r_dn[s]  <= n_in;
                for (int p = 0; p < 6; p++) begin
                    sh = {rem_in[p], n_in[p][BIT]};
                    if (sh >= d_in) begin
                        r_drem[s][p] <= 31'(sh - d_in);
                        r_dq[s][p]   <= {q_in[p][DIV_STAGES-2:0], 1'b1};
                    end else begin
                        r_drem[s][p] <= sh[30:0];
                        r_dq[s][p]   <= {q_in[p][DIV_STAGES-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // S5: clamped terms, forces
    logic             r_s5_v;
    t_meta            r_s5_meta;
    logic [31:0]      r_s5_ks;
    logic             r_s5_jon;
    logic [2:0][31:0] r_s5_frc;
    logic [5:0][31:0] r_s5_tm;
    logic [5:0]       r_s5_tn;

    localparam int DL = DIV_STAGES - 1;

    always_ff @(posedge i_clk) begin
        logic [63:0]           fp;
        logic [DIV_STAGES:0]   dsum;
        logic [DIV_STAGES-1:0] q;
        logic                  tn;
        if (en) begin
            r_s5_meta <= r_dm[DL];
            r_s5_ks   <= r_dks[DL];
            r_s5_jon  <= i_cfg.jac_en && (r_dd[DL] != '0);
            for (int i = 0; i < 3; i++) begin
                fp = {32'd0, r_dkd[DL]} * {32'd0, r_dm[DL].mag[i]};
                r_s5_frc[i] <= pack(!r_dm[DL].neg[i] && (r_dm[DL].mag[i] != '0), fp[63:16]);
            end
            for (int p = 0; p < 6; p++) begin
                q = r_dq[DL][p];
                if (PAIR_I[p] == PAIR_J[p]) begin
                    dsum = {1'b0, q} + (DIV_STAGES+1)'(r_dd[DL]);
                    r_s5_tn[p] <= 1'b0;
                    r_s5_tm[p] <= (dsum > (DIV_STAGES+1)'(32'h7FFF_FFFF))
                                  ? 32'h7FFF_FFFF : dsum[31:0];
                end else begin
                    tn = (r_dm[DL].neg[PAIR_I[p]] != r_dm[DL].neg[PAIR_J[p]]) && (q != '0);
                    r_s5_tn[p] <= tn;
                    if (tn)
                        r_s5_tm[p] <= (q > DIV_STAGES'(32'h8000_0000)) ? 32'h8000_0000 : q[31:0];
                    else
                        r_s5_tm[p] <= (q > DIV_STAGES'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
                end
            end
        end
    end

    // S6: output register
    logic r_out_v;
    t_res r_out;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        logic [63:0] jp;
        if (en) begin
            r_out.idx    <= r_s5_meta.idx;
            r_out.last   <= r_s5_meta.last;
            r_out.active <= r_s5_meta.active;
            r_out.frc    <= r_s5_meta.active ? r_s5_frc : '0;
            for (int p = 0; p < 6; p++) begin
                jp = {32'd0, r_s5_ks} * {32'd0, r_s5_tm[p]};
                r_out.jac[p] <= (r_s5_meta.active && r_s5_jon)
                                ? pack(r_s5_tn[p], jp[63:16]) : 32'd0;
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int s = 0; s < SQ_STAGES; s++) r_qv[s] <= 1'b0;
            for (int s = 0; s < DIV_STAGES; s++) r_dv[s] <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_qv[0] <= r_s2_v;
            for (int s = 1; s < SQ_STAGES; s++) r_qv[s] <= r_qv[s-1];
            r_s3_v <= r_qv[SQ_STAGES-1];
            r_s4_v <= r_s3_v;
            r_dv[0] <= r_s4_v;
            for (int s = 1; s < DIV_STAGES; s++) r_dv[s] <= r_dv[s-1];
            r_s5_v  <= r_dv[DIV_STAGES-1];
            r_out_v <= r_s5_v;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/sphere_quadratic_drag.sv]
// Quadratic drag on an immersed sphere with its 3x3 Jacobian, Q16.16 saturating.
// One ball per cycle sustained while results are popped; the pipeline depth is set by the
// bit-per-stage square root and the bit-per-stage dividers that form d_i*d_j/|d|. The
// front classifies a ball (active test, saturated relative velocity) and drops it into a
// small queue; the back pulls from that queue and moves all its stages together whenever
// its output register is empty or being popped, so a held result stalls the back and,
// once the queue fills, the front. Config writes are registered; write them only while
// the block is drained.
// Depends on sphq_pkg, sphq_front, sphq_fifo, sphq_back.
`default_nettype none
module sphere_quadratic_drag #(
    parameter int QUEUE_DEPTH = sphq_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_wdata,
    // input queue side
    input  wire         push,
    output logic        full,
    input  wire  [15:0] i_node_index,
    input  wire  [31:0] i_node_vel_x,
    input  wire  [31:0] i_node_vel_y,
    input  wire  [31:0] i_node_vel_z,
    input  wire  [31:0] i_water_vel_x,
    input  wire  [31:0] i_water_vel_y,
    input  wire  [31:0] i_water_vel_z,
    input  wire  [31:0] i_node_height,
    input  wire  [31:0] i_ball_radius,
    input  wire  [31:0] i_birth_time,
    input  wire  [31:0] i_sim_time,
    input  wire         i_last_ball,
    // result queue side
    output logic        empty,
    input  wire         pop,
    output logic [15:0] o_out_node_index,
    output logic        o_active,
    output logic [31:0] o_force_x,
    output logic [31:0] o_force_y,
    output logic [31:0] o_force_z,
    output logic [31:0] o_jac_xx,
    output logic [31:0] o_jac_xy,
    output logic [31:0] o_jac_xz,
    output logic [31:0] o_jac_yy,
    output logic [31:0] o_jac_yz,
    output logic [31:0] o_jac_zz,
    output logic        o_result_last
);
    import sphq_pkg::*;

    // config registers
    t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drag_coef <= 32'd26214;
            r_cfg.density   <= 32'd67174400;
            r_cfg.jac_scale <= 32'd65536;
            r_cfg.jac_en    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DRAG_COEF: r_cfg.drag_coef <= i_cfg_wdata;
                CFG_DENSITY:   r_cfg.density   <= i_cfg_wdata;
                CFG_JAC_SCALE: r_cfg.jac_scale <= i_cfg_wdata;
                CFG_JAC_EN:    r_cfg.jac_en    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic  fr_valid, q_full, q_valid, bk_rd, bk_valid;
    t_item fr_item, q_item;
    t_res  res;

    sphq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_node_index  (i_node_index),
        .i_vel         ({i_node_vel_z, i_node_vel_y, i_node_vel_x}),
        .i_wvel        ({i_water_vel_z, i_water_vel_y, i_water_vel_x}),
        .i_node_height (i_node_height),
        .i_ball_radius (i_ball_radius),
        .i_birth_time  (i_birth_time),
        .i_sim_time    (i_sim_time),
        .i_last_ball   (i_last_ball),
        .o_valid       (fr_valid),
        .o_item        (fr_item),
        .i_ready       (!q_full)
    );

    sphq_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fr_valid),
        .i_wdata (fr_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (q_item),
        .i_rd    (bk_rd)
    );

    sphq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_rd    (bk_rd),
        .o_valid (bk_valid),
        .o_res   (res),
        .i_pop   (pop)
    );

    assign empty            = !bk_valid;
    assign o_out_node_index = res.idx;
    assign o_active         = res.active;
    assign o_force_x        = res.frc[0];
    assign o_force_y        = res.frc[1];
    assign o_force_z        = res.frc[2];
    assign o_jac_xx         = res.jac[0];
    assign o_jac_xy         = res.jac[1];
    assign o_jac_xz         = res.jac[2];
    assign o_jac_yy         = res.jac[3];
    assign o_jac_yz         = res.jac[4];
    assign o_jac_zz         = res.jac[5];
    assign o_result_last    = res.last;

`ifndef SYNTHESIS
    // an inactive ball carries no force and zero xx, xy and zz Jacobian entries
    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_active |-> o_force_x == '0 && o_force_y == '0 && o_force_z == '0
                                && o_jac_xx == '0 && o_jac_xy == '0 && o_jac_zz == '0)
        else $error("inactive ball with nonzero terms");
    // diagonal entries are never negative
    a_diag_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !o_jac_xx[31] && !o_jac_yy[31] && !o_jac_zz[31])
        else $error("negative Jacobian diagonal");
    // reset drains the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");
`endif

endmodule
`default_nettype wire
